// File: rtl/rr_pkg.sv
// Shared constants and types for the rank reduction block.
`default_nettype none

package rr_pkg;

    localparam int MAX_VALUES = 64;
    localparam int ADDR_W     = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CNT_W      = $clog2(MAX_VALUES + 1);
    localparam int VALUE_W    = 32;
    localparam int RANK_W     = 6;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Write port of the value store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        value_t            data;
    } rr_wr_t;

endpackage

`default_nettype wire

// File: rtl/rr_if.sv
// Valid/ready channel interfaces for the sample input and the rank output.
`default_nettype none

interface rr_in_if;
    import rr_pkg::*;

    logic   valid;
    logic   ready;
    value_t sample_value;
    logic   final_item;

    modport source (output valid, output sample_value, output final_item, input ready);
    modport sink (input valid, input sample_value, input final_item, output ready);
endinterface

interface rr_out_if;
    import rr_pkg::*;

    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;
    logic              final_rank;
    logic              overflow;

    modport source (output valid, output rank, output final_rank, output overflow, input ready);
    modport sink (input valid, input rank, input final_rank, input overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/rr_store.sv
// Value store: one write port and one read port with registered read data.
`default_nettype none

module rr_store (
    input  wire logic                      clk,
    input  wire rr_pkg::rr_wr_t            wr,
    input  wire logic [rr_pkg::ADDR_W-1:0] rd_addr,
    output rr_pkg::value_t                 rd_data
);
    import rr_pkg::*;

    value_t mem [MAX_VALUES];
    value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/rank_reduction.sv
// Top level of the rank reduction block: loads a set of values, then emits their ranks.
// Ranks are worked out one at a time once the last item is accepted: for each rank the
// one read port fetches the rank's own key, then walks all stored values through one
// comparator, and the rank waits in the hold state until the output register is free.
// Samples are taken one per cycle while a set loads, and none while ranks run. Reset (rst_n,
// asynchronous) clears the count, the overflow flag and the sequencer, but not the store.
`default_nettype none

module rank_reduction (
    input  wire logic clk,
    input  wire logic rst_n,
    rr_in_if.sink     samples,
    rr_out_if.source  ranks
);
    import rr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_KEY,
        S_WALK,
        S_HOLD
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] cmp_idx_reg;
    logic [ADDR_W-1:0] acc_reg;
    value_t            key_reg;

    logic              out_valid_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              final_rank_reg;
    logic              overflow_reg;

    rr_wr_t            wr;
    logic [ADDR_W-1:0] rd_addr;
    value_t            rd_data;

    logic              in_accept;
    logic              store_full;
    logic              walk_last;
    logic              pos_last;
    logic              counts;
    logic              out_free;

    rr_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign samples.ready = (state_reg == S_IDLE);
    assign in_accept     = samples.valid && samples.ready;
    assign store_full    = (count_reg == CNT_W'(MAX_VALUES));

    // A new value goes to the next free entry unless the store is already full.
    assign wr.en   = in_accept && !store_full;
    assign wr.addr = count_reg[ADDR_W-1:0];
    assign wr.data = samples.sample_value;

    // The fetch state reads the key of the value being ranked; afterwards the walk
    // reads entry cmp_idx+1 while entry cmp_idx is on the read data.
    always_comb
    begin
        case (state_reg)
            S_FETCH: rd_addr = pos_reg;
            S_KEY:   rd_addr = '0;
            default: rd_addr = cmp_idx_reg + ADDR_W'(1);
        endcase
    end

    assign walk_last = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg);
    assign pos_last  = ((CNT_W'(pos_reg) + CNT_W'(1)) == count_reg);

    // A stored value counts toward the rank if it is smaller, or equal and earlier.
    assign counts = (rd_data < key_reg) || ((rd_data == key_reg) && (cmp_idx_reg < pos_reg));

    assign out_free = !out_valid_reg || ranks.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pos_reg        <= '0;
            cmp_idx_reg    <= '0;
            acc_reg        <= '0;
            key_reg        <= '0;
            out_valid_reg  <= 1'b0;
            rank_reg       <= '0;
            final_rank_reg <= 1'b0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            // In the hold state the output register is refilled whenever it frees up,
            // so the plain drain applies only in the other states.
            if (out_valid_reg && ranks.ready && (state_reg != S_HOLD))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (store_full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (samples.final_item)
                        begin
                            pos_reg   <= '0;
                            state_reg <= S_FETCH;
                        end
                    end
                end

                S_FETCH:
                begin
                    state_reg <= S_KEY;
                end

                S_KEY:
                begin
                    key_reg     <= rd_data;
                    cmp_idx_reg <= '0;
                    acc_reg     <= '0;
                    state_reg   <= S_WALK;
                end

                S_WALK:
                begin
                    if (counts)
                    begin
                        acc_reg <= acc_reg + ADDR_W'(1);
                    end
                    if (walk_last)
                    begin
                        state_reg <= S_HOLD;
                    end
                    else
                    begin
                        cmp_idx_reg <= cmp_idx_reg + ADDR_W'(1);
                    end
                end

                S_HOLD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        rank_reg       <= RANK_W'(acc_reg);
                        final_rank_reg <= pos_last;
                        overflow_reg   <= ovf_reg;
                        if (pos_last)
                        begin
                            // The whole set has been ranked: start a new one.
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            pos_reg   <= pos_reg + ADDR_W'(1);
                            state_reg <= S_FETCH;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign ranks.valid      = out_valid_reg;
    assign ranks.rank       = rank_reg;
    assign ranks.final_rank = final_rank_reg;
    assign ranks.overflow   = overflow_reg;

endmodule

`default_nettype wire
